>>> rtl/core/segx_pkg.sv
package segx_pkg;

   // packed request fields, lowest bits first
   localparam int unsigned NUM_COORDS = 8;

   // fixed result layout width for hit flag
   localparam int unsigned HIT_BITS = 1;

endpackage

>>> rtl/core/segx_front.sv
module segx_front #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned PROD_WIDTH  = 2 * COORD_WIDTH + 3
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [8*COORD_WIDTH-1:0]     in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [COORD_WIDTH-1:0]       out_px,
   output logic [COORD_WIDTH-1:0]       out_py,
   output logic [COORD_WIDTH:0]         out_d1x,
   output logic [COORD_WIDTH:0]         out_d1y,
   output logic                         out_hit,
   output logic [PROD_WIDTH-1:0]        out_num,
   output logic [PROD_WIDTH-1:0]        out_den
);
   import segx_pkg::*;

   localparam int unsigned DW = COORD_WIDTH + 1;

   // stage 1: differences
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [DW-1:0]    d1x_ff, d1y_ff, d2x_ff, d2y_ff, wx_ff, wy_ff;
   logic [COORD_WIDTH-1:0]  px1_ff, py1_ff;
   // stage 2: products
   logic                    s2_valid_ff;
   logic signed [PROD_WIDTH-1:0] p_a_ff, p_b_ff, p_c_ff, p_d_ff, p_e_ff, p_f_ff;
   logic signed [DW-1:0]    d1x2_ff, d1y2_ff;
   logic [COORD_WIDTH-1:0]  px2_ff, py2_ff;
   // stage 3: classification
   logic                    s3_valid_ff;
   logic                    hit_ff;
   logic [PROD_WIDTH-1:0]   num_ff, den_ff;
   logic signed [DW-1:0]    d1x3_ff, d1y3_ff;
   logic [COORD_WIDTH-1:0]  px3_ff, py3_ff;

   logic advance;
   logic signed [COORD_WIDTH-1:0] c [NUM_COORDS];
   logic signed [PROD_WIDTH-1:0]  den_w, ns_w, nt_w, den_a, ns_a, nt_a;
   logic den_neg;

   // whole pipe moves together when the last stage can drain
   assign advance  = !s3_valid_ff || out_ready;
   assign in_ready = advance;
   assign s1_valid_in = in_valid;

   always_comb begin
      for (int i = 0; i < NUM_COORDS; i++) begin
         c[i] = in_data[i*COORD_WIDTH +: COORD_WIDTH];
      end
   end

   // signed cross products, normalized to a non-negative denominator
   assign den_w   = p_a_ff - p_b_ff;
   assign ns_w    = p_c_ff - p_d_ff;
   assign nt_w    = p_e_ff - p_f_ff;
   assign den_neg = den_w[PROD_WIDTH-1];
   assign den_a   = den_neg ? -den_w : den_w;
   assign ns_a    = den_neg ? -ns_w : ns_w;
   assign nt_a    = den_neg ? -nt_w : nt_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1x_ff <= DW'(c[2]) - DW'(c[0]);
         d1y_ff <= DW'(c[3]) - DW'(c[1]);
         d2x_ff <= DW'(c[6]) - DW'(c[4]);
         d2y_ff <= DW'(c[7]) - DW'(c[5]);
         wx_ff  <= DW'(c[0]) - DW'(c[4]);
         wy_ff  <= DW'(c[1]) - DW'(c[5]);
         px1_ff <= c[0];
         py1_ff <= c[1];
         p_a_ff <= PROD_WIDTH'(d1x_ff) * PROD_WIDTH'(d2y_ff);
         p_b_ff <= PROD_WIDTH'(d2x_ff) * PROD_WIDTH'(d1y_ff);
         p_c_ff <= PROD_WIDTH'(d1x_ff) * PROD_WIDTH'(wy_ff);
         p_d_ff <= PROD_WIDTH'(d1y_ff) * PROD_WIDTH'(wx_ff);
         p_e_ff <= PROD_WIDTH'(d2x_ff) * PROD_WIDTH'(wy_ff);
         p_f_ff <= PROD_WIDTH'(d2y_ff) * PROD_WIDTH'(wx_ff);
         d1x2_ff <= d1x_ff;
         d1y2_ff <= d1y_ff;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         hit_ff  <= (den_w != '0) && !ns_a[PROD_WIDTH-1] && (ns_a <= den_a)
                    && !nt_a[PROD_WIDTH-1] && (nt_a <= den_a);
         num_ff  <= nt_a;
         den_ff  <= den_a;
         d1x3_ff <= d1x2_ff;
         d1y3_ff <= d1y2_ff;
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_px    = px3_ff;
   assign out_py    = py3_ff;
   assign out_d1x   = d1x3_ff;
   assign out_d1y   = d1y3_ff;
   assign out_hit   = hit_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

   // a hit never carries a numerator above the denominator
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && hit_ff |-> num_ff <= den_ff)
      else $error("numerator exceeds denominator on hit");
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && hit_ff |-> den_ff != '0)
      else $error("hit with zero denominator");
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_ready |=> s3_valid_ff)
      else $error("front result lost under stall");
endmodule

>>> rtl/core/segx_queue.sv
module segx_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH_LOG = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);
   import segx_pkg::*;

   localparam int unsigned DEPTH = 1 << DEPTH_LOG;

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [DEPTH_LOG:0] wp_ff, rp_ff;
   logic               wr_fire, rd_fire;

   assign wr_ready = (wp_ff - rp_ff) != (DEPTH_LOG+1)'(DEPTH);
   assign rd_valid = wp_ff != rp_ff;
   assign wr_fire  = wr_valid && wr_ready;
   assign rd_fire  = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rp_ff[DEPTH_LOG-1:0]];

   // pointer update
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         if (wr_fire) wp_ff <= wp_ff + 1'b1;
         if (rd_fire) rp_ff <= rp_ff + 1'b1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_fire) mem_ff[wp_ff[DEPTH_LOG-1:0]] <= wr_data;
   end

   assert property (@(posedge clock) disable iff (reset)
      (wp_ff - rp_ff) <= (DEPTH_LOG+1)'(DEPTH))
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      rd_fire && !wr_fire |=> (wp_ff - rp_ff) == $past(wp_ff - rp_ff) - 1'b1)
      else $error("queue count slip");
   assert property (@(posedge clock) disable iff (reset)
      !rd_valid |-> wp_ff == rp_ff)
      else $error("queue empty flag");
endmodule

>>> rtl/core/segx_back.sv
module segx_back #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned PROD_WIDTH  = 2 * COORD_WIDTH + 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [COORD_WIDTH-1:0] in_px,
   input  logic [COORD_WIDTH-1:0] in_py,
   input  logic [COORD_WIDTH:0]   in_d1x,
   input  logic [COORD_WIDTH:0]   in_d1y,
   input  logic                   in_hit,
   input  logic [PROD_WIDTH-1:0]  in_num,
   input  logic [PROD_WIDTH-1:0]  in_den,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_hit,
   output logic [COORD_WIDTH-1:0] out_x,
   output logic [COORD_WIDTH-1:0] out_y
);
   import segx_pkg::*;

   // pipelined restoring scaler: one magnitude bit of d per stage
   localparam int unsigned MW = COORD_WIDTH + 1;
   localparam int unsigned NS = MW + 1;
   localparam int unsigned RW = PROD_WIDTH + 2;

   logic               v_ff [NS];
   logic               hit_ff [NS];
   logic [PROD_WIDTH-1:0] num_ff [NS];
   logic [PROD_WIDTH-1:0] den_ff [NS];
   logic [RW-1:0]      rx_ff [NS];
   logic [RW-1:0]      ry_ff [NS];
   logic [MW-1:0]      qx_ff [NS];
   logic [MW-1:0]      qy_ff [NS];
   logic [MW-1:0]      mx_ff [NS];
   logic [MW-1:0]      my_ff [NS];
   logic               nx_ff [NS];
   logic               ny_ff [NS];
   logic [COORD_WIDTH-1:0] px_ff [NS];
   logic [COORD_WIDTH-1:0] py_ff [NS];

   logic advance;
   logic [MW-1:0] ax, ay;
   logic [MW-1:0] qfx, qfy;

   assign advance  = !v_ff[NS-1] || out_ready;
   assign in_ready = advance;
   assign ax = in_d1x[MW-1] ? -in_d1x : in_d1x;
   assign ay = in_d1y[MW-1] ? -in_d1y : in_d1y;

   // one quotient digit, 0 to 2, per stage for x and y
   function automatic logic [RW+MW:0] stepq(input logic [RW-1:0] r,
         input logic mbit, input logic [PROD_WIDTH-1:0] num,
         input logic [PROD_WIDTH-1:0] den, input logic [MW-1:0] q);
      logic [RW-1:0] t;
      logic [MW-1:0] qq;
      t  = {r[RW-2:0], 1'b0} + (mbit ? RW'(num) : RW'(0));
      qq = {q[MW-2:0], 1'b0};
      if (t >= RW'(den)) begin t = t - RW'(den); qq = qq + 1'b1; end
      if (t >= RW'(den)) begin t = t - RW'(den); qq = qq + 1'b1; end
      return {1'b0, t, qq};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) v_ff[i] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      logic [RW+MW:0] sx, sy;
      if (advance) begin
         hit_ff[0] <= in_hit;
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         rx_ff[0]  <= '0;
         ry_ff[0]  <= '0;
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
         mx_ff[0]  <= ax;
         my_ff[0]  <= ay;
         nx_ff[0]  <= in_d1x[MW-1];
         ny_ff[0]  <= in_d1y[MW-1];
         px_ff[0]  <= in_px;
         py_ff[0]  <= in_py;
         for (int i = 1; i < NS; i++) begin
            sx = stepq(rx_ff[i-1], mx_ff[i-1][MW-i], num_ff[i-1], den_ff[i-1],
                       qx_ff[i-1]);
            sy = stepq(ry_ff[i-1], my_ff[i-1][MW-i], num_ff[i-1], den_ff[i-1],
                       qy_ff[i-1]);
            rx_ff[i]  <= sx[RW+MW-1:MW];
            qx_ff[i]  <= sx[MW-1:0];
            ry_ff[i]  <= sy[RW+MW-1:MW];
            qy_ff[i]  <= sy[MW-1:0];
            hit_ff[i] <= hit_ff[i-1];
            num_ff[i] <= num_ff[i-1];
            den_ff[i] <= den_ff[i-1];
            mx_ff[i]  <= mx_ff[i-1];
            my_ff[i]  <= my_ff[i-1];
            nx_ff[i]  <= nx_ff[i-1];
            ny_ff[i]  <= ny_ff[i-1];
            px_ff[i]  <= px_ff[i-1];
            py_ff[i]  <= py_ff[i-1];
         end
      end
   end

   // final signed offset and gating on miss
   assign qfx = nx_ff[NS-1] ? -qx_ff[NS-1] : qx_ff[NS-1];
   assign qfy = ny_ff[NS-1] ? -qy_ff[NS-1] : qy_ff[NS-1];
   assign out_valid = v_ff[NS-1];
   assign out_hit   = hit_ff[NS-1];
   assign out_x = hit_ff[NS-1] ? px_ff[NS-1] + qfx[COORD_WIDTH-1:0] : '0;
   assign out_y = hit_ff[NS-1] ? py_ff[NS-1] + qfy[COORD_WIDTH-1:0] : '0;

   assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !out_ready |=> v_ff[NS-1] && $stable(out_x))
      else $error("back result changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && !hit_ff[NS-1] |-> out_x == '0 && out_y == '0)
      else $error("miss with nonzero point");
   assert property (@(posedge clock) disable iff (reset)
      v_ff[NS-1] && hit_ff[NS-1] |-> qx_ff[NS-1] <= mx_ff[NS-1])
      else $error("offset exceeds direction");
endmodule

>>> rtl/core/segment_intersection_unit.sv
// channel | ports      | fields
// input   | req_t*     | tdata: 8 coordinates
// result  | rsp_t*     | tdata: hit, cross_x, cross_y
// one segment pair per cycle while rsp_tready is high; 3 front stages,
// queue, COORD_WIDTH+2 scaler stages, quotient digit in all but first
// reset clears all valid flags and queue pointers; no clearing pass
// front stalls only when the queue is full, back stalls on rsp_tready
module segment_intersection_unit #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_start_x, first_start_y, first_end_x, first_end_y,
   // second_start_x, second_start_y, second_end_x, second_end_y
   input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // hit, cross_x, cross_y
   output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] rsp_tdata
);
   import segx_pkg::*;

   localparam int unsigned PW = 2 * COORD_WIDTH + 3;
   localparam int unsigned QW = 4 * COORD_WIDTH + 2 + HIT_BITS + 2 * PW;
   localparam int unsigned OW = ((2*COORD_WIDTH+1+7)/8)*8;
   // binary point is common to all coordinates
   localparam int unsigned POINT = FRAC_BITS;

   logic f_valid, f_ready, b_valid, b_ready, f_hit, b_hit, o_hit;
   logic [COORD_WIDTH-1:0] f_px, f_py, b_px, b_py, ox, oy;
   logic [COORD_WIDTH:0]   f_dx, f_dy, b_dx, b_dy;
   logic [PW-1:0] f_num, f_den, b_num, b_den;
   logic [QW-1:0] qw, qr;

   segx_front #(.COORD_WIDTH(COORD_WIDTH), .PROD_WIDTH(PW)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata[8*COORD_WIDTH-1:0]), .out_valid(f_valid),
      .out_ready(f_ready), .out_px(f_px), .out_py(f_py), .out_d1x(f_dx),
      .out_d1y(f_dy), .out_hit(f_hit), .out_num(f_num), .out_den(f_den));

   assign qw = {f_px, f_py, f_dx, f_dy, f_hit, f_num, f_den};
   assign {b_px, b_py, b_dx, b_dy, b_hit, b_num, b_den} = qr;

   segx_queue #(.WIDTH(QW), .DEPTH_LOG(2)) u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(qw),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(qr));

   segx_back #(.COORD_WIDTH(COORD_WIDTH), .PROD_WIDTH(PW)) u_back (
      .clock, .reset, .in_valid(b_valid), .in_ready(b_ready), .in_px(b_px),
      .in_py(b_py), .in_d1x(b_dx), .in_d1y(b_dy), .in_hit(b_hit),
      .in_num(b_num), .in_den(b_den), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_hit(o_hit), .out_x(ox), .out_y(oy));

   assign rsp_tdata = OW'({oy, ox, o_hit}) | OW'(POINT & 0);
endmodule
